// File: hw/rtl/wermon_pkg.sv
// ----------------------------------------------------------------------------
// wermon_pkg
// Shared types and constants of the weighted event rate monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package wermon_pkg;

  localparam int unsigned STAMP_W        = 48;
  localparam int unsigned RATE_W         = 32;
  localparam int unsigned WINDOW_W       = 32;
  localparam int unsigned WEIGHT_W       = 17;
  localparam int unsigned MUL_A_W        = 32;
  localparam int unsigned MUL_B_W        = 17;
  localparam int unsigned PROD_W         = MUL_A_W + MUL_B_W;
  localparam int unsigned RATE_SCALE_W   = 14;
  localparam int unsigned RING_DEPTH_DEF = 64;

  localparam logic [WEIGHT_W-1:0] ONE_Q16      = 17'h10000;
  localparam logic [MUL_B_W-1:0]  DECAY_Q16    = 17'd64881;
  localparam logic [MUL_B_W-1:0]  RATE_SCALE   = 17'd15625;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd1000000;

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_QUERY  = 1'b1
  } req_e;

endpackage

`default_nettype wire

// File: hw/rtl/wermon_ram.sv
// ----------------------------------------------------------------------------
// wermon_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wermon_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/wermon_mul.sv
// ----------------------------------------------------------------------------
// wermon_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module wermon_mul
  import wermon_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic [MUL_A_W-1:0] a_i,
  input  wire logic [MUL_B_W-1:0] b_i,
  output logic      [PROD_W-1:0]  prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= PROD_W'(a_i) * PROD_W'(b_i);
  end

endmodule

`default_nettype wire

// File: hw/rtl/wermon_div.sv
// ----------------------------------------------------------------------------
// wermon_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wermon_div #(
  parameter int unsigned DIVD_W = 37,
  parameter int unsigned DVSR_W = 57
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIVD_W-1:0] dividend_i,
  input  wire logic [DVSR_W-1:0] divisor_i,
  output logic                   done_o,
  output logic      [DIVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVD_W + 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVD_W-1:0] dq_q;
  logic [DVSR_W-1:0] rem_q;
  logic [DVSR_W-1:0] dvsr_q;
  logic [DVSR_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, dq_q[DIVD_W-1]};
  assign fits  = trial >= {1'b0, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= busy_q && !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q   <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DVSR_W'(trial - {1'b0, dvsr_q}) : DVSR_W'(trial);
      dq_q  <= {dq_q[DIVD_W-2:0], fits};
    end
  end

  assign quotient_o = dq_q;

endmodule

`default_nettype wire

// File: hw/rtl/weighted_event_rate_monitor_core.sv
// ----------------------------------------------------------------------------
// weighted_event_rate_monitor_core
// Ring of event timestamps with a query that walks back over the ring and
// returns the decay-weighted event rate through a shared multiplier and an
// iterative divider.
// ----------------------------------------------------------------------------
// record beat: taken in ST_IDLE, ready stays high, no result
// query beat: walks back over n entries with the six-step sequence per entry
//   around the shared multiplier, then runs the divider
// one item at a time; s_axis_tready is low for the whole query walk
// reset: fill count and write pointer cleared, window 1000000 us, ring data
//   left unwritten, so no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_event_rate_monitor_core
  import wermon_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [WINDOW_W-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [47:0]         s_axis_tdata,   // timestamp_us[47:0]
  input  wire logic [0:0]          s_axis_tuser,   // req_type[0]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [31:0]              m_axis_tdata,   // rate_fps_q8[31:0]
  output logic [0:0]               m_axis_tuser    // rate_saturated[0]
);

  localparam int unsigned PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned WSUM_W = WEIGHT_W + $clog2(RING_DEPTH);
  localparam int unsigned TSUM_W = STAMP_W + $clog2(RING_DEPTH) + 1;
  localparam int unsigned DIVD_W = WSUM_W + RATE_SCALE_W;
  localparam int unsigned DVSR_W = TSUM_W + 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NWAIT,
    ST_NEWEST,
    ST_FETCH,
    ST_LOAD,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_MUL_DECAY,
    ST_ACCUM,
    ST_CALC,
    ST_DSTART,
    ST_DWAIT,
    ST_RESULT
  } state_e;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(RING_DEPTH - 1) : PTR_W'(p - 1'b1);
  endfunction

  state_e              state_q;
  logic                out_valid_q;
  logic [RATE_W-1:0]   out_rate_q;
  logic                out_sat_q;
  logic [PTR_W-1:0]    wp_q;
  logic [FILL_W-1:0]   fill_q;
  logic [WINDOW_W-1:0] window_q;

  logic [PTR_W-1:0]    pos_q;
  logic [STAMP_W-1:0]  newest_q;
  logic [STAMP_W-1:0]  later_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [WSUM_W-1:0]   wsum_q;
  logic [TSUM_W-1:0]   tsum_q;
  logic [PTR_W-1:0]    steps_q;
  logic [STAMP_W-1:0]  mag_q;
  logic                neg_q;
  logic [STAMP_W-1:0]  term_q;
  logic                stop_q;
  logic [RATE_W-1:0]   res_rate_q;
  logic                res_sat_q;

  logic                in_acc;
  logic                ram_we;
  logic [STAMP_W-1:0]  rdata;
  logic                slot_valid;
  logic                stamp_late;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   prod_q;
  logic                div_start;
  logic                div_done;
  logic [DIVD_W-1:0]   quotient;
  logic [63:0]         quot_ext;
  logic                quot_over;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign ram_we        = in_acc && (s_axis_tuser[0] == REQ_RECORD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_rate_q;
  assign m_axis_tuser  = out_sat_q;

  assign slot_valid = FILL_W'(pos_q) < fill_q;
  assign stamp_late = rdata > newest_q;
  assign div_start  = (state_q == ST_DSTART);
  assign quot_ext   = 64'(quotient);
  assign quot_over  = |quot_ext[63:32];

  wermon_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (RING_DEPTH),
    .ADDR_W(PTR_W)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(s_axis_tdata),
    .raddr_i(pos_q),
    .rdata_o(rdata)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_HI: begin
        mul_a = mag_q[47:16];
        mul_b = weight_q;
      end
      ST_MUL_LO: begin
        mul_a = MUL_A_W'(mag_q[15:0]);
        mul_b = weight_q;
      end
      ST_MUL_DECAY: begin
        mul_a = MUL_A_W'(weight_q);
        mul_b = DECAY_Q16;
      end
      ST_CALC: begin
        mul_a = MUL_A_W'(wsum_q);
        mul_b = RATE_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  wermon_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod_q)
  );

  wermon_div #(
    .DIVD_W(DIVD_W),
    .DVSR_W(DVSR_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_q[DIVD_W-1:0]),
    .divisor_i ({tsum_q, 2'b00}),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_rate_q  <= '0;
      out_sat_q   <= 1'b0;
      wp_q        <= '0;
      fill_q      <= '0;
      window_q    <= WINDOW_RESET;
    end else begin
      if (cfg_valid_i) begin
        window_q <= cfg_data_i;
      end
      if (m_axis_tready && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser[0] == REQ_RECORD) begin
              wp_q <= ptr_next(wp_q);
              if (fill_q != FILL_W'(RING_DEPTH)) begin
                fill_q <= fill_q + 1'b1;
              end
            end else if (fill_q == '0) begin
              state_q <= ST_RESULT;
            end else begin
              state_q <= ST_NWAIT;
            end
          end
        end
        ST_NWAIT:     state_q <= ST_NEWEST;
        ST_NEWEST:    state_q <= ST_FETCH;
        ST_FETCH:     state_q <= slot_valid ? ST_LOAD : ST_CALC;
        ST_LOAD:      state_q <= stamp_late ? ST_CALC : ST_MUL_HI;
        ST_MUL_HI:    state_q <= ST_MUL_LO;
        ST_MUL_LO:    state_q <= ST_MUL_DECAY;
        ST_MUL_DECAY: state_q <= ST_ACCUM;
        ST_ACCUM: begin
          if (stop_q || (steps_q == PTR_W'(RING_DEPTH - 2))) begin
            state_q <= ST_CALC;
          end else begin
            state_q <= ST_FETCH;
          end
        end
        ST_CALC: begin
          if ((steps_q == '0) || (tsum_q == '0) || tsum_q[TSUM_W-1]) begin
            state_q <= ST_RESULT;
          end else begin
            state_q <= ST_DSTART;
          end
        end
        ST_DSTART: state_q <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_rate_q  <= res_rate_q;
            out_sat_q   <= res_sat_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pos_q      <= ptr_prev(wp_q);
          res_rate_q <= '0;
          res_sat_q  <= 1'b0;
        end
      end
      ST_NEWEST: begin
        newest_q <= rdata;
        later_q  <= rdata;
        weight_q <= ONE_Q16;
        wsum_q   <= '0;
        tsum_q   <= '0;
        steps_q  <= '0;
        pos_q    <= ptr_prev(pos_q);
      end
      ST_LOAD: begin
        if (!stamp_late) begin
          neg_q   <= later_q < rdata;
          mag_q   <= (later_q < rdata) ? (rdata - later_q) : (later_q - rdata);
          later_q <= rdata;
        end
      end
      ST_MUL_HI: begin
        stop_q <= (newest_q - later_q) > STAMP_W'(window_q);
      end
      ST_MUL_LO: begin
        term_q <= prod_q[STAMP_W-1:0];
      end
      ST_MUL_DECAY: begin
        term_q <= term_q + STAMP_W'(prod_q >> 16);
      end
      ST_ACCUM: begin
        tsum_q   <= neg_q ? (tsum_q - TSUM_W'(term_q)) : (tsum_q + TSUM_W'(term_q));
        wsum_q   <= wsum_q + WSUM_W'(weight_q);
        weight_q <= WEIGHT_W'((prod_q + PROD_W'(32768)) >> 16);
        steps_q  <= steps_q + 1'b1;
        pos_q    <= ptr_prev(pos_q);
      end
      ST_CALC: begin
        if (steps_q == '0) begin
          res_rate_q <= '0;
          res_sat_q  <= 1'b0;
        end else if (tsum_q == '0) begin
          res_rate_q <= '1;
          res_sat_q  <= 1'b1;
        end else if (tsum_q[TSUM_W-1]) begin
          res_rate_q <= '0;
          res_sat_q  <= 1'b1;
        end
      end
      ST_DWAIT: begin
        if (div_done) begin
          res_rate_q <= quot_over ? '1 : quot_ext[31:0];
          res_sat_q  <= quot_over;
        end
      end
      default: begin
      end
    endcase
  end

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(RING_DEPTH))
    else $error("fill count above ring depth");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser[0] == REQ_QUERY)) |=> !s_axis_tready)
    else $error("ready right after a query beat");

  a_record_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> ((fill_q == $past(fill_q) + 1'b1) || (fill_q == FILL_W'(RING_DEPTH))))
    else $error("record beat did not advance fill count");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DWAIT))
    else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted event rate monitor core. Record and
// query beats go in on the input stream; each query's rate beat is compared
// field by field with the table's rate or, if untyped, with a rate from an
// in-bench copy of the ring walk, decay weighting and division. A short
// table of corner cases is followed by randomized phases, each run with a
// different averaging window. Random gaps and stalls act on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import wermon_pkg::*;

  localparam int    DEPTH        = RING_DEPTH_DEF;
  localparam int    QUERY_CYCLES = 6 * DEPTH + 160;
  localparam int    LIMIT        = 2000000;
  localparam int    N_DIRECTED   = 20;
  localparam logic [47:0] N_STAMP = 48'h5555_AAAA_5555;

  typedef struct packed {
    logic [31:0] rate;
    logic        sat;
  } rate_beat_t;

  typedef struct packed {
    req_e        req;
    logic [47:0] ts;
    logic        typed;
    logic [31:0] rate;
    logic        sat;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
    '{REQ_QUERY,  48'd0,                 1'b1, 32'd0,          1'b0}, // empty ring
    '{REQ_RECORD, 48'd1000,              1'b0, 32'd0,          1'b0},
    '{REQ_QUERY,  48'd0,                 1'b1, 32'd0,          1'b0}, // one stamp only
    '{REQ_RECORD, 48'd1000,              1'b0, 32'd0,          1'b0},
    '{REQ_QUERY,  48'hFFFF_FFFF_FFFF,    1'b1, 32'hFFFF_FFFF,  1'b1}, // zero span
    '{REQ_RECORD, 48'd0,                 1'b0, 32'd0,          1'b0},
    '{REQ_QUERY,  48'd0,                 1'b1, 32'd0,          1'b0}, // older is later
    '{REQ_RECORD, 48'hFFFF_FFFF_FFFF,    1'b0, 32'd0,          1'b0},
    '{REQ_QUERY,  48'd0,                 1'b0, 32'd0,          1'b0}, // huge span
    '{REQ_RECORD, N_STAMP,               1'b0, 32'd0,          1'b0},
    '{REQ_RECORD, N_STAMP - 48'd3,       1'b0, 32'd0,          1'b0},
    '{REQ_RECORD, N_STAMP - 48'd2,       1'b0, 32'd0,          1'b0},
    '{REQ_RECORD, N_STAMP - 48'd1,       1'b0, 32'd0,          1'b0},
    '{REQ_RECORD, N_STAMP,               1'b0, 32'd0,          1'b0},
    '{REQ_RECORD, N_STAMP,               1'b0, 32'd0,          1'b0},
    '{REQ_QUERY,  48'd0,                 1'b0, 32'd0,          1'b0}, // negative sum
    '{REQ_RECORD, N_STAMP + 48'd16667,   1'b0, 32'd0,          1'b0},
    '{REQ_RECORD, N_STAMP + 48'd33334,   1'b0, 32'd0,          1'b0},
    '{REQ_QUERY,  48'hAAAA_5555_AAAA,    1'b0, 32'd0,          1'b0},
    '{REQ_RECORD, 48'hAAAA_5555_AAAA,    1'b0, 32'd0,          1'b0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;  // timestamp_us[47:0]
  logic [0:0]  s_axis_tuser  = '0;  // req_type[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // rate_fps_q8[31:0]
  logic [0:0]  m_axis_tuser;        // rate_saturated[0]

  logic [47:0] stamp_mem [DEPTH];
  logic        stamp_set [DEPTH];
  int          next_slot;
  logic [31:0] window_us;
  rate_beat_t  pending_rates [$];
  int          errors;
  int          cycle_count;
  logic        steady;
  logic [47:0] cur_stamp;

  weighted_event_rate_monitor_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // floor(mag * w / 2^16) without overflowing 64 bits
  function automatic logic [63:0] scale_q16(input logic [47:0] mag,
                                            input logic [63:0] w);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = {16'd0, mag} >> 16;
    lo = {48'd0, mag[15:0]};
    return hi * w + ((lo * w) >> 16);
  endfunction

  function automatic rate_beat_t predict_rate();
    rate_beat_t  res;
    int          pos;
    int          steps;
    int          count;
    logic        done;
    logic [47:0] newest;
    logic [47:0] later;
    logic [47:0] t;
    logic [63:0] weight;
    logic [63:0] wsum;
    logic [63:0] q;
    longint      tsum;
    res    = '0;
    pos    = (next_slot + DEPTH - 1) % DEPTH;
    if (!stamp_set[pos]) return res;
    newest = stamp_mem[pos];
    later  = newest;
    weight = 64'(ONE_Q16);
    wsum   = '0;
    tsum   = 0;
    count  = 0;
    steps  = 0;
    done   = 1'b0;
    while (!done && steps < DEPTH - 1) begin
      steps++;
      pos = (pos + DEPTH - 1) % DEPTH;
      t   = stamp_mem[pos];
      if (!stamp_set[pos] || t > newest) begin
        done = 1'b1;
      end else begin
        wsum += weight;
        if (later >= t) tsum += longint'(scale_q16(later - t, weight));
        else            tsum -= longint'(scale_q16(t - later, weight));
        weight = (weight * 64'(DECAY_Q16) + 64'd32768) >> 16;
        later  = t;
        count++;
        if ({16'd0, newest - t} > {32'd0, window_us}) done = 1'b1;
      end
    end
    if (count == 0) return res;
    if (tsum == 0) begin
      res = '{32'hFFFF_FFFF, 1'b1};
    end else if (tsum < 0) begin
      res = '{32'd0, 1'b1};
    end else begin
      q = (wsum * 64'(RATE_SCALE)) / (64'(tsum) * 64'd4);
      if (q > 64'hFFFF_FFFF) res = '{32'hFFFF_FFFF, 1'b1};
      else                   res = '{q[31:0], 1'b0};
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic [47:0] next_stamp(input logic [47:0] prev);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return prev;
    if (r < 30) return prev + 48'($urandom_range(1, 3));
    if (r < 75) return prev + 48'($urandom_range(16000, 17300));
    if (r < 85) return prev + 48'($urandom_range(0, 2000000));
    if (r < 92) return prev - 48'($urandom_range(1, 50000));
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic send_item(input req_e req, input logic [47:0] ts, input logic typed,
                           input rate_beat_t typed_rate);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ts;
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    if (req == REQ_RECORD) begin
      stamp_mem[next_slot] = ts;
      stamp_set[next_slot] = 1'b1;
      next_slot = (next_slot + 1) % DEPTH;
    end else if (typed) begin
      pending_rates.push_back(typed_rate);
    end else begin
      pending_rates.push_back(predict_rate());
    end
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_window(input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk_i);
    repeat (QUERY_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    window_us = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input int items);
    int sent;
    int k;
    int r;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // run of equal stamps, then a one-microsecond step and a query
        k = $urandom_range(10, 40);
        repeat (k) send_item(REQ_RECORD, cur_stamp, 1'b0, '0);
        cur_stamp += 48'd1;
        send_item(REQ_RECORD, cur_stamp, 1'b0, '0);
        send_item(REQ_QUERY, 48'({$urandom(), $urandom()}), 1'b0, '0);
        sent += k + 2;
      end else if (r < 31) begin
        send_item(REQ_QUERY, 48'({$urandom(), $urandom()}), 1'b0, '0);
        sent++;
      end else begin
        cur_stamp = next_stamp(cur_stamp);
        send_item(REQ_RECORD, cur_stamp, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    rate_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_rates.size() == 0) begin
        report_mismatch("unexpected rate beat", {32'd0, m_axis_tdata}, '0);
      end else begin
        want = pending_rates.pop_front();
        if (m_axis_tdata !== want.rate)
          report_mismatch("rate_fps_q8", {32'd0, m_axis_tdata}, {32'd0, want.rate});
        if (m_axis_tuser[0] !== want.sat)
          report_mismatch("rate_saturated", {63'd0, m_axis_tuser[0]}, {63'd0, want.sat});
      end
    end
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    m_axis_tready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    errors      = 0;
    cycle_count = 0;
    next_slot   = 0;
    window_us   = WINDOW_RESET;
    steady      = 1'b0;
    cur_stamp   = 48'({$urandom(), $urandom()});
    for (int i = 0; i < DEPTH; i++) begin
      stamp_mem[i] = '0;
      stamp_set[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].ts, DIRECTED_ROWS[i].typed,
                '{DIRECTED_ROWS[i].rate, DIRECTED_ROWS[i].sat});

    write_window(32'd0);
    run_phase(90);
    write_window(32'hFFFF_FFFF);
    run_phase(90);
    write_window(32'd100);
    steady = 1'b1;
    run_phase(90);
    steady = 1'b0;
    write_window($urandom());
    run_phase(90);
    write_window(32'd20000);
    run_phase(90);
    write_window(WINDOW_RESET);
    run_phase(90);

    s_axis_tvalid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk_i);
    repeat (QUERY_CYCLES) @(posedge clk_i);
    if (pending_rates.size() != 0)
      report_mismatch("rate beats never seen", 64'(pending_rates.size()), '0);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/wermon_pkg.sv
hw/rtl/wermon_ram.sv
hw/rtl/wermon_mul.sv
hw/rtl/wermon_div.sv
hw/rtl/weighted_event_rate_monitor_core.sv
tb/sv/tb.sv
